// ===== src/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the touch slot event tracker.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int Slots    = 5;
  localparam int SlotW    = 3;
  localparam int CountW   = 4;
  localparam int RCountW  = $clog2(Slots + 1);
  localparam int IdxW     = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int CoordW   = 12;
  localparam int WeightW  = 8;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CFG_MAX_X = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_MAX_Y = CfgIdxW'(1);

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } event_e;

  typedef struct packed {
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [WeightW-1:0] w;
  } slot_entry_t;

endpackage

// ===== src/tse_intf.sv =====
// ----------------------------------------------------------------------------
// tse_intf
// Handshake channels of the touch slot event tracker: slot items in, events
// out, and the register write channel.
// ----------------------------------------------------------------------------
interface tse_in_if;
  logic                       valid;
  logic                       ready;
  logic [tse_pkg::CountW-1:0]  touch_count;
  logic [tse_pkg::SlotW-1:0]   slot;
  logic [tse_pkg::CoordW-1:0]  pos_x;
  logic [tse_pkg::CoordW-1:0]  pos_y;
  logic [tse_pkg::WeightW-1:0] weight;
  logic                       frame_end;

  modport source (output valid, touch_count, slot, pos_x, pos_y, weight, frame_end,
                  input ready);
  modport sink   (input valid, touch_count, slot, pos_x, pos_y, weight, frame_end,
                  output ready);
endinterface

interface tse_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 event_res;
  logic [tse_pkg::SlotW-1:0]   track_slot;
  logic [tse_pkg::CoordW-1:0]  out_x;
  logic [tse_pkg::CoordW-1:0]  out_y;
  logic [tse_pkg::WeightW-1:0] out_weight;
  logic                       last;

  modport source (output valid, event_res, track_slot, out_x, out_y, out_weight, last,
                  input ready);
  modport sink   (input valid, event_res, track_slot, out_x, out_y, out_weight, last,
                  output ready);
endinterface

interface tse_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tse_pkg::CfgIdxW-1:0]  index;
  logic [tse_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tse_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tse_slot_mem
// Per-slot point store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tse_slot_mem (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [tse_pkg::IdxW-1:0]  rd_addr_i,
  output tse_pkg::slot_entry_t      rd_data_o,
  input  logic                      wr_en_i,
  input  logic [tse_pkg::IdxW-1:0]  wr_addr_i,
  input  tse_pkg::slot_entry_t      wr_data_i
);
  import tse_pkg::*;

  slot_entry_t mem_q [Slots];
  slot_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/touch_slot_event_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_slot_event_tracker
// Turns per-slot touch reports into down, move and up events.
// ----------------------------------------------------------------------------
// One slot item is taken per clock cycle and gives exactly one event item in
// the output register. The slot's held point is first read from the point
// store; then the item is compared, the store is written back and the output
// register is loaded. A same-slot item right behind another is served
// by a bypass of the last store write, so nothing stalls but a full output
// register that is not taken. Registers max_x (index 0) and max_y (index 1)
// are written through the configuration channel, which is always ready.
module touch_slot_event_tracker (
  input  logic      clk_i,
  input  logic      rst_ni,
  tse_cfg_if.sink   cfg_i,
  tse_in_if.sink    in_i,
  tse_out_if.source out_o
);
  import tse_pkg::*;

  localparam logic [SlotW-1:0]   SlotLim  = SlotW'(Slots);
  localparam logic [CountW-1:0]  CountLim = CountW'(Slots);

  // configuration
  logic [CoordW-1:0] max_x_q, max_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= '1;
      max_y_q <= '1;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_MAX_X) max_x_q <= cfg_i.data[CoordW-1:0];
      if (cfg_i.index == CFG_MAX_Y) max_y_q <= cfg_i.data[CoordW-1:0];
    end
  end

  // stage 1 registers
  logic                s1_valid_q;
  logic [RCountW-1:0]  s1_count_q;
  logic [SlotW-1:0]    s1_slot_q;
  logic [CoordW-1:0]   s1_x_q, s1_y_q;
  logic [WeightW-1:0]  s1_w_q;
  logic                s1_fend_q;

  // output register
  logic                out_valid_q;
  event_e              out_ev_q;
  logic [SlotW-1:0]    out_slot_q;
  logic [CoordW-1:0]   out_x_q, out_y_q;
  logic [WeightW-1:0]  out_w_q;
  logic                out_last_q;

  // tracker state
  logic [Slots-1:0]    held_q, held_d;
  logic [RCountW-1:0]  prev_count_q, prev_count_d;
  logic                aborted_q, aborted_d;

  // bypass of the last store write
  logic                fwd_valid_q;
  logic [IdxW-1:0]     fwd_idx_q;
  slot_entry_t         fwd_data_q;

  logic                in_fire, s1_fire;
  logic [IdxW-1:0]     rd_addr, s1_idx;
  slot_entry_t         rd_data, ent, wr_data;
  logic                in_range, down_zone, up_zone, held, hit;
  logic                abort_now, do_dm, do_up, mem_we;
  event_e              ev;
  logic [CoordW-1:0]   ev_x, ev_y;
  logic [WeightW-1:0]  ev_w;

  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign rd_addr  = (in_i.slot < SlotLim) ? in_i.slot[IdxW-1:0] : '0;

  tse_slot_mem u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_idx),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      // repair a count beyond the slot number to zero
      s1_count_q <= (in_i.touch_count > CountLim) ? '0 : in_i.touch_count[RCountW-1:0];
      s1_slot_q  <= in_i.slot;
      s1_x_q     <= in_i.pos_x;
      s1_y_q     <= in_i.pos_y;
      s1_w_q     <= in_i.weight;
      s1_fend_q  <= in_i.frame_end;
    end
  end

  assign s1_idx = s1_slot_q[IdxW-1:0];
  assign ent    = (fwd_valid_q && fwd_idx_q == s1_idx) ? fwd_data_q : rd_data;

  always_comb begin
    in_range  = s1_slot_q < SlotLim;
    held      = in_range && held_q[s1_idx];
    down_zone = in_range && (s1_slot_q < s1_count_q);
    up_zone   = in_range && !down_zone && (s1_slot_q < prev_count_q);
    hit       = held && ent.x == s1_x_q && ent.y == s1_y_q;
    abort_now = down_zone && !aborted_q && (s1_x_q > max_x_q || s1_y_q > max_y_q);
    do_dm     = down_zone && !aborted_q && !abort_now && !hit;
    do_up     = up_zone && held;
    mem_we    = s1_fire && do_dm;
    wr_data   = '{x: s1_x_q, y: s1_y_q, w: s1_w_q};

    ev   = EV_NONE;
    ev_x = '0;
    ev_y = '0;
    ev_w = '0;
    if (do_dm) begin
      ev   = held ? EV_MOVE : EV_DOWN;
      ev_x = s1_x_q;
      ev_y = s1_y_q;
      ev_w = s1_w_q;
    end else if (do_up) begin
      ev   = EV_UP;
      ev_x = ent.x;
      ev_y = ent.y;
      ev_w = ent.w;
    end

    held_d = held_q;
    if (do_dm) held_d[s1_idx] = 1'b1;
    if (do_up) held_d[s1_idx] = 1'b0;

    aborted_d    = aborted_q || abort_now;
    prev_count_d = prev_count_q;
    if (s1_fend_q) begin
      if (!aborted_d) prev_count_d = s1_count_q;
      aborted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      prev_count_q <= '0;
      aborted_q    <= 1'b0;
      fwd_valid_q  <= 1'b0;
    end else if (s1_fire) begin
      held_q       <= held_d;
      prev_count_q <= prev_count_d;
      aborted_q    <= aborted_d;
      if (mem_we) fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fwd_idx_q  <= s1_idx;
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ev_q   <= ev;
      out_slot_q <= s1_slot_q;
      out_x_q    <= ev_x;
      out_y_q    <= ev_y;
      out_w_q    <= ev_w;
      out_last_q <= s1_fend_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_res  = out_ev_q;
  assign out_o.track_slot = out_slot_q;
  assign out_o.out_x      = out_x_q;
  assign out_o.out_y      = out_y_q;
  assign out_o.out_weight = out_w_q;
  assign out_o.last       = out_last_q;

  // an up drops the slot's point
  a_up_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && do_up) |=> !held_q[$past(s1_idx)])
    else $error("slot still held after up");

  // a down or move leaves the slot held
  a_dm_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && do_dm) |=> held_q[$past(s1_idx)])
    else $error("slot not held after down or move");

  a_fend_clears_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_fend_q) |=> !aborted_q)
    else $error("abort survives frame end");

  a_prev_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_count_q <= RCountW'(Slots))
    else $error("previous count beyond slot number");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ev_q == EV_NONE) |->
      (out_x_q == '0 && out_y_q == '0 && out_w_q == '0))
    else $error("empty event carries a point");

endmodule

// ===== verif/tse_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tse_event_checker
// Watches the slot, event and register channels of the touch slot event
// tracker, predicts one event per accepted slot item and compares each
// accepted event field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tse_event_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tse_cfg_if   cfg_i,
  tse_in_if    slot_i,
  tse_out_if   event_i,
  output int   fail_cnt_o,
  output int   pending_o
);
  import tse_pkg::*;

  typedef struct packed {
    event_e             kind;
    logic [SlotW-1:0]   slot;
    slot_entry_t        pt;
    logic               last;
  } touch_event_t;

  localparam int MaxPrinted = 50;

  logic [CoordW-1:0] lim_x;
  logic [CoordW-1:0] lim_y;
  slot_entry_t       held_pt[Slots];
  logic              point_held[Slots];
  logic              is_down[Slots];
  int                prev_count;
  logic              frame_aborted;
  touch_event_t      expected_events[$];

  task automatic report_fail(input string msg);
    if (fail_cnt_o < MaxPrinted) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    fail_cnt_o++;
  endtask

  // Advance the tracking state by one slot item and return the event it gives.
  function automatic touch_event_t track_touch(input logic [CountW-1:0]  cnt_in,
                                               input logic [SlotW-1:0]   slot,
                                               input logic [CoordW-1:0]  x,
                                               input logic [CoordW-1:0]  y,
                                               input logic [WeightW-1:0] w,
                                               input logic               fend);
    touch_event_t res;
    int cnt;
    int s;
    cnt = (cnt_in > Slots) ? 0 : int'(cnt_in);
    s = int'(slot);
    res = '0;
    res.kind = EV_NONE;
    res.slot = slot;
    res.last = fend;
    if (s < Slots) begin
      if (s < cnt) begin
        if (!frame_aborted) begin
          if (x > lim_x || y > lim_y) begin
            frame_aborted = 1'b1;
          end else if (!(point_held[s] && held_pt[s].x == x && held_pt[s].y == y)) begin
            res.kind = is_down[s] ? EV_MOVE : EV_DOWN;
            is_down[s] = 1'b1;
            point_held[s] = 1'b1;
            held_pt[s] = '{x: x, y: y, w: w};
            res.pt = held_pt[s];
          end
        end
      end else if (s < prev_count) begin
        // drop the held point; only a slot that is down reports up
        if (point_held[s]) begin
          if (is_down[s]) begin
            res.kind = EV_UP;
            res.pt = held_pt[s];
          end
          is_down[s] = 1'b0;
          point_held[s] = 1'b0;
          held_pt[s] = '0;
        end
      end
    end
    if (fend) begin
      if (!frame_aborted) prev_count = cnt;
      frame_aborted = 1'b0;
    end
    return res;
  endfunction

  task automatic check_event();
    touch_event_t want;
    if (expected_events.size() == 0) begin
      report_fail($sformatf("event for slot %0d with no item pending", event_i.track_slot));
      return;
    end
    want = expected_events.pop_front();
    if (event_i.event_res !== want.kind)
      report_fail($sformatf("slot %0d: event %0d, want %0d",
                            want.slot, event_i.event_res, want.kind));
    if (event_i.track_slot !== want.slot)
      report_fail($sformatf("track_slot %0d, want %0d", event_i.track_slot, want.slot));
    if (event_i.out_x !== want.pt.x)
      report_fail($sformatf("slot %0d: x %0d, want %0d", want.slot, event_i.out_x, want.pt.x));
    if (event_i.out_y !== want.pt.y)
      report_fail($sformatf("slot %0d: y %0d, want %0d", want.slot, event_i.out_y, want.pt.y));
    if (event_i.out_weight !== want.pt.w)
      report_fail($sformatf("slot %0d: weight %0d, want %0d",
                            want.slot, event_i.out_weight, want.pt.w));
    if (event_i.last !== want.last)
      report_fail($sformatf("slot %0d: last %0b, want %0b", want.slot, event_i.last, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_x = '1;
      lim_y = '1;
      for (int i = 0; i < Slots; i++) begin
        held_pt[i] = '0;
        point_held[i] = 1'b0;
        is_down[i] = 1'b0;
      end
      prev_count = 0;
      frame_aborted = 1'b0;
      expected_events.delete();
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      // an event never belongs to an item taken at the same edge
      if (event_i.valid && event_i.ready) check_event();
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_MAX_X: lim_x = cfg_i.data;
          CFG_MAX_Y: lim_y = cfg_i.data;
          default: ;
        endcase
      end
      if (slot_i.valid && slot_i.ready) begin
        expected_events.push_back(track_touch(slot_i.touch_count, slot_i.slot, slot_i.pos_x,
                                              slot_i.pos_y, slot_i.weight, slot_i.frame_end));
      end
      pending_o <= expected_events.size();
    end
  end

endmodule

// ===== verif/tb_touch_slot_event_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_slot_event_tracker
// Drives touch frames into the slot event tracker under several coordinate
// limits and idle patterns; the event checker beside the block predicts and
// compares every event item.
// ----------------------------------------------------------------------------
module tb_touch_slot_event_tracker;
  import tse_pkg::*;

  localparam int LatencyCycles = 2;
  localparam int ItemsPerPhase = 255;
  localparam int CoordMax      = (1 << CoordW) - 1;

  logic clk_i;
  logic rst_ni;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   lim_x = CoordMax;
  int   lim_y = CoordMax;
  int   sent_x[Slots];
  int   sent_y[Slots];
  int   slot_items;
  int   fail_cnt;
  int   pending;

  tse_cfg_if cfg_if ();
  tse_in_if  in_if ();
  tse_out_if out_if ();

  touch_slot_event_tracker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tse_event_checker i_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_if),
    .slot_i     (in_if),
    .event_i    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_report(input int   cnt,
                             input int   slot,
                             input int   x,
                             input int   y,
                             input int   w,
                             input logic fend);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.touch_count <= CountW'(cnt);
    in_if.slot        <= SlotW'(slot);
    in_if.pos_x       <= CoordW'(x);
    in_if.pos_y       <= CoordW'(y);
    in_if.weight      <= WeightW'(w);
    in_if.frame_end   <= fend;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (slot < Slots) begin
      sent_x[slot] = x;
      sent_y[slot] = y;
      slot_items++;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[CfgDataW-1:0];
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_MAX_X) lim_x = value;
    else lim_y = value;
  endtask

  // Hold the input low until every predicted event has been taken.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LatencyCycles + 2) @(posedge clk_i);
  endtask

  // Mostly repeat or nudge the slot's last point so that no-change and move
  // events stay frequent; sometimes jump anywhere, beyond the limit too.
  function automatic int pick_coord(input int prev, input int lim);
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 35) return prev;
    if (roll < 70) begin
      v = prev + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > CoordMax) v = CoordMax;
      return v;
    end
    if (roll < 90) return $urandom_range(lim, 0);
    return $urandom_range(CoordMax);
  endfunction

  task automatic send_frame();
    int   cnt;
    int   len;
    logic extra;
    if ($urandom_range(99) < 85) begin
      cnt = ($urandom_range(99) < 85) ? $urandom_range(Slots) : $urandom_range(15, Slots + 1);
      extra = ($urandom_range(99) < 15);
      for (int s = 0; s < Slots; s++) begin
        send_report(cnt, s, pick_coord(sent_x[s], lim_x), pick_coord(sent_y[s], lim_y),
                    $urandom_range(255), (s == Slots - 1) && !extra);
      end
      // close the frame on a slot the block does not track
      if (extra) send_report(cnt, $urandom_range(7, Slots), $urandom_range(CoordMax),
                             $urandom_range(CoordMax), $urandom_range(255), 1'b1);
    end else begin
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        send_report($urandom_range(15), $urandom_range(7), $urandom_range(CoordMax),
                    $urandom_range(CoordMax), $urandom_range(255), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int nx;
    int ny;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.touch_count <= '0;
    in_if.slot        <= '0;
    in_if.pos_x       <= '0;
    in_if.pos_y       <= '0;
    in_if.weight      <= '0;
    in_if.frame_end   <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    for (int i = 0; i < Slots; i++) begin
      sent_x[i] = 0;
      sent_y[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 20;
    rx_idle_pct = 86;
    // reset limits: down, no change, move, up, repaired count, empty event for a slot with no point
    send_report(2, 0, 0, 0, 0, 1'b0);
    send_report(2, 1, CoordMax, CoordMax, 255, 1'b1);
    send_report(2, 0, 0, 0, 17, 1'b0);
    send_report(2, 1, 5, 6, 7, 1'b1);
    send_report(1, 0, 1, 1, 8, 1'b0);
    send_report(1, 1, 300, 300, 9, 1'b1);
    send_report(9, 0, 2, 2, 10, 1'b0);
    send_report(9, 1, 2, 2, 10, 1'b1);
    send_report(15, 7, CoordMax, CoordMax, 255, 1'b1);
    settle();
    write_reg(CFG_MAX_X, 100);
    write_reg(CFG_MAX_Y, 200);
    // points at the limit, then an aborted frame that keeps the old count
    send_report(2, 0, 50, 50, 9, 1'b0);
    send_report(2, 1, 60, 200, 3, 1'b1);
    send_report(3, 0, 50, 50, 1, 1'b0);
    send_report(3, 1, 101, 0, 2, 1'b0);
    send_report(3, 2, 10, 10, 3, 1'b0);
    send_report(3, 3, 10, 10, 3, 1'b1);
    send_report(0, 0, 0, 0, 0, 1'b0);
    send_report(0, 1, 0, 0, 0, 1'b0);
    send_report(1, 2, 0, 0, 0, 1'b1);
    send_report(1, 0, 0, 201, 0, 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 20 : (p < 4) ? 86 : 0;
      rx_idle_pct = (p < 2) ? 86 : (p < 4) ? 20 : 0;
      case (p)
        0: begin nx = CoordMax; ny = CoordMax; end
        1: begin nx = 0;        ny = CoordMax; end
        3: begin nx = CoordMax; ny = 0;        end
        4: begin nx = 0;        ny = 0;        end
        default: begin
          nx = $urandom_range(CoordMax);
          ny = $urandom_range(CoordMax);
        end
      endcase
      write_reg(CFG_MAX_X, nx);
      write_reg(CFG_MAX_Y, ny);
      slot_items = 0;
      while (slot_items < ItemsPerPhase) send_frame();
      settle();
    end

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d events outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tse_pkg.sv
src/tse_intf.sv
src/tse_slot_mem.sv
src/touch_slot_event_tracker.sv
verif/tse_event_checker.sv
verif/tb_touch_slot_event_tracker.sv
